### hdl/hsfp_pkg.sv
// Package for the five-point heat stencil step.
// Holds widths, limits, register indexes, the queue word type and helpers.
// No dependencies; every other file but hsfp_ram imports it.
package hsfp_pkg;

    // Field widths
    localparam int TEMP_W      = 32;
    localparam int ROW_W       = 12;
    localparam int COL_W       = 8;
    localparam int COEFF_W     = 15;
    localparam int COLS_W      = 9;
    localparam int ROWS_W      = 13;
    localparam int FRAC_W      = 16;

    // Grid limits
    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 4096;
    localparam int MIN_DIM     = 3;

    // Arithmetic widths: Laplacian, product and the unsaturated sum
    localparam int LAP_W       = TEMP_W + 3;
    localparam int PROD_W      = LAP_W + COEFF_W + 1;
    localparam int SUM_W       = LAP_W + 1;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_COEFF   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMNS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROWS    = 2'd2;

    // Register reset values
    localparam logic [COEFF_W-1:0] COEFF_RESET   = 15'd66;
    localparam logic [COLS_W-1:0]  COLUMNS_RESET = 9'd200;
    localparam logic [ROWS_W-1:0]  ROWS_RESET    = 13'd200;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    typedef logic signed [TEMP_W-1:0] temp_t;

    // One classified word as it travels from front to back
    typedef struct packed {
        temp_t              cell_temperature;
        logic [ROW_W-1:0]   row;       // row of the arriving cell
        logic [COL_W-1:0]   col;
        logic               emit_upper; // emit the cell of the row above
        logic               border;     // that cell lies on the grid border
        logic               emit_self;  // arriving cell is on the last row
        logic               last;       // arriving cell closes the grid
    } hsfp_item_t;

    function automatic logic signed [LAP_W-1:0] sext_lap(input temp_t v);
        return {{(LAP_W-TEMP_W){v[TEMP_W-1]}}, v};
    endfunction

endpackage

### hdl/hsfp_cell_if.sv
// Input channel of the heat stencil: one grid cell per word.
// Depends on hsfp_pkg.
interface hsfp_cell_if;
    import hsfp_pkg::*;

    logic  valid;
    logic  ready;
    temp_t cell_temperature;
    logic  grid_start;

    modport source (output valid, cell_temperature, grid_start, input ready);
    modport sink   (input valid, cell_temperature, grid_start, output ready);
endinterface

### hdl/hsfp_result_if.sv
// Output channel of the heat stencil: one updated cell per word.
// Depends on hsfp_pkg.
interface hsfp_result_if;
    import hsfp_pkg::*;

    logic             valid;
    logic             ready;
    temp_t            new_temperature;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_column;
    logic             last_of_grid;

    modport source (output valid, new_temperature, out_row, out_column, last_of_grid,
                    input ready);
    modport sink   (input valid, new_temperature, out_row, out_column, last_of_grid,
                    output ready);
endinterface

### hdl/hsfp_cfg_if.sv
// Configuration write channel of the heat stencil.
// Depends on hsfp_pkg.
interface hsfp_cfg_if;
    import hsfp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/hsfp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hsfp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and read the old contents on an address collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hdl/hsfp_queue.sv
// Short word queue between the stencil front and back.
// Depends on hsfp_pkg.
module hsfp_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  hsfp_pkg::hsfp_item_t push_item,
    output logic               full,
    input  logic               pop,
    output hsfp_pkg::hsfp_item_t head_item,
    output logic               empty
);
    import hsfp_pkg::*;

    hsfp_item_t         slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W:0]   count_reg;

    assign full      = (count_reg == Q_DEPTH[Q_PTR_W:0]);
    assign empty     = (count_reg == '0);
    assign head_item = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store words
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_DEPTH[Q_PTR_W:0])
        else $error("queue occupancy beyond depth");

    a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue occupancy did not grow on push");

endmodule

### hdl/hsfp_front.sv
// Stencil front: configuration registers, raster position tracking and
// classification of each arriving cell. Depends on hsfp_pkg and the interfaces.
module hsfp_front (
    input  logic                          clk,
    input  logic                          rst_n,
    hsfp_cell_if.sink                     cells,
    hsfp_cfg_if.sink                      cfg,
    input  logic                          q_full,
    output logic                          push,
    output hsfp_pkg::hsfp_item_t          push_item,
    output logic [hsfp_pkg::COEFF_W-1:0]  coeff
);
    import hsfp_pkg::*;

    logic [COEFF_W-1:0] coeff_reg;
    logic [COLS_W-1:0]  columns_reg;
    logic [ROWS_W-1:0]  rows_reg;
    logic [COL_W-1:0]   col_pos_reg;
    logic [COL_W-1:0]   col_pos_next;
    logic [ROW_W-1:0]   row_pos_reg;
    logic [ROW_W-1:0]   row_pos_next;

    logic [COLS_W-1:0]  cols_eff;
    logic [ROWS_W-1:0]  rows_eff;
    logic [COLS_W-1:0]  cur_col;
    logic [ROWS_W-1:0]  cur_row;
    logic [COLS_W-1:0]  nxt_col;
    logic [ROWS_W-1:0]  nxt_row;
    logic [ROWS_W-1:0]  upper_row;

    // Configuration writes; always ready
    assign cfg.ready = 1'b1;
    assign coeff     = coeff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg   <= COEFF_RESET;
            columns_reg <= COLUMNS_RESET;
            rows_reg    <= ROWS_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_COEFF:   coeff_reg   <= cfg.data[COEFF_W-1:0];
                CFG_COLUMNS: columns_reg <= cfg.data[COLS_W-1:0];
                CFG_ROWS:    rows_reg    <= cfg.data[ROWS_W-1:0];
                default:     ;
            endcase
        end
    end

    // Clamp grid size to the supported range
    always_comb
    begin
        cols_eff = columns_reg;
        if (columns_reg < COLS_W'(MIN_DIM))
        begin
            cols_eff = COLS_W'(MIN_DIM);
        end
        else if (columns_reg > COLS_W'(MAX_COLUMNS))
        begin
            cols_eff = COLS_W'(MAX_COLUMNS);
        end
        rows_eff = rows_reg;
        if (rows_reg < ROWS_W'(MIN_DIM))
        begin
            rows_eff = ROWS_W'(MIN_DIM);
        end
        else if (rows_reg > ROWS_W'(MAX_ROWS))
        begin
            rows_eff = ROWS_W'(MAX_ROWS);
        end
    end

    // Place the arriving cell, wrapping a stale position
    always_comb
    begin
        cur_col = {1'b0, col_pos_reg};
        cur_row = {1'b0, row_pos_reg};
        if (cells.grid_start)
        begin
            cur_col = '0;
            cur_row = '0;
        end
        else
        begin
            if (cur_col >= cols_eff)
            begin
                cur_col = '0;
                cur_row = cur_row + 1'b1;
            end
            if (cur_row >= rows_eff)
            begin
                cur_row = '0;
            end
        end

        nxt_col = cur_col + 1'b1;
        nxt_row = cur_row;
        if (nxt_col >= cols_eff)
        begin
            nxt_col = '0;
            nxt_row = cur_row + 1'b1;
            if (nxt_row >= rows_eff)
            begin
                nxt_row = '0;
            end
        end
        col_pos_next = nxt_col[COL_W-1:0];
        row_pos_next = nxt_row[ROW_W-1:0];
        upper_row    = cur_row - 1'b1;
    end

    // Classify the word for the back
    always_comb
    begin
        push_item.cell_temperature = cells.cell_temperature;
        push_item.row        = cur_row[ROW_W-1:0];
        push_item.col        = cur_col[COL_W-1:0];
        push_item.emit_upper = (cur_row != '0);
        push_item.border     = (upper_row == '0) || (upper_row == rows_eff - 1'b1) ||
                               (cur_col == '0) || (cur_col == cols_eff - 1'b1);
        push_item.emit_self  = (cur_row == rows_eff - 1'b1);
        push_item.last       = (cur_col == cols_eff - 1'b1) &&
                               (cur_row == rows_eff - 1'b1);
    end

    assign cells.ready = !q_full;
    assign push        = cells.valid && !q_full;

    // Hold raster position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end
        else if (push)
        begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
        end
    end

endmodule

### hdl/hsfp_back.sv
// Stencil back: line stores, Laplacian, coefficient product, saturation and
// the output register that emits up to two results per word.
// Depends on hsfp_pkg, hsfp_ram and hsfp_result_if.
module hsfp_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [hsfp_pkg::COEFF_W-1:0]  coeff,
    input  logic                          q_empty,
    input  hsfp_pkg::hsfp_item_t          q_head,
    output logic                          pop,
    hsfp_result_if.source                 results
);
    import hsfp_pkg::*;

    logic adv;

    // Read stage: line store data arrives
    logic       b_valid_reg;
    hsfp_item_t b_item_reg;
    temp_t      center_q;
    temp_t      east_q;
    temp_t      north_q;
    temp_t      west_reg;

    // Laplacian stage
    logic                    c_valid_reg;
    hsfp_item_t              c_item_reg;
    temp_t                   c_center_reg;
    logic signed [LAP_W-1:0] lap_next;
    logic signed [LAP_W-1:0] c_lap_reg;

    // Product stage
    logic                     p_valid_reg;
    hsfp_item_t               p_item_reg;
    temp_t                    p_center_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] p_prod_reg;

    // Output stage
    logic                    d_valid_reg;
    logic                    d_pend_upper_reg;
    logic                    d_pend_self_reg;
    temp_t                   d_upper_reg;
    temp_t                   d_self_reg;
    logic [ROW_W-1:0]        d_row_reg;
    logic [COL_W-1:0]        d_col_reg;
    logic                    d_last_reg;
    logic signed [SUM_W-1:0] sum;
    temp_t                   upper_next;
    logic                    d_finish;

    // Advance the whole pipe when the output word frees up
    assign d_finish = d_valid_reg && results.ready &&
                      !(d_pend_upper_reg && d_pend_self_reg);
    assign adv      = !d_valid_reg || d_finish;
    assign pop      = adv && !q_empty;

    // Line stores: row above twice (center and east taps), row two above once
    hsfp_ram #(.WIDTH(TEMP_W), .DEPTH(MAX_COLUMNS)) u_prev_center (
        .clk   (clk),
        .we    (adv && b_valid_reg),
        .waddr (b_item_reg.col),
        .wdata (b_item_reg.cell_temperature),
        .re    (pop),
        .raddr (q_head.col),
        .rdata (center_q)
    );

    hsfp_ram #(.WIDTH(TEMP_W), .DEPTH(MAX_COLUMNS)) u_prev_east (
        .clk   (clk),
        .we    (adv && b_valid_reg),
        .waddr (b_item_reg.col),
        .wdata (b_item_reg.cell_temperature),
        .re    (pop),
        .raddr (q_head.col + 1'b1),
        .rdata (east_q)
    );

    hsfp_ram #(.WIDTH(TEMP_W), .DEPTH(MAX_COLUMNS)) u_prev2 (
        .clk   (clk),
        .we    (adv && b_valid_reg),
        .waddr (b_item_reg.col),
        .wdata (center_q),
        .re    (pop),
        .raddr (q_head.col),
        .rdata (north_q)
    );

    // Form the Laplacian n + s + w + e - 4a
    always_comb
    begin
        lap_next = sext_lap(north_q) + sext_lap(b_item_reg.cell_temperature) +
                   sext_lap(west_reg) + sext_lap(east_q) - (sext_lap(center_q) <<< 2);
    end

    assign prod_next = c_lap_reg * $signed({1'b0, coeff});

    // Scale by k, floor the fraction, add and saturate; border cells pass through
    always_comb
    begin
        sum = {{(SUM_W-TEMP_W){p_center_reg[TEMP_W-1]}}, p_center_reg} +
              SUM_W'($signed(p_prod_reg[PROD_W-1:FRAC_W]));
        if (sum[SUM_W-1:TEMP_W-1] == '0 || sum[SUM_W-1:TEMP_W-1] == '1)
        begin
            upper_next = sum[TEMP_W-1:0];
        end
        else if (sum[SUM_W-1])
        begin
            upper_next = {1'b1, {(TEMP_W-1){1'b0}}};
        end
        else
        begin
            upper_next = {1'b0, {(TEMP_W-1){1'b1}}};
        end
        if (p_item_reg.border)
        begin
            upper_next = p_center_reg;
        end
    end

    // Stage valids and pending results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg      <= 1'b0;
            c_valid_reg      <= 1'b0;
            p_valid_reg      <= 1'b0;
            d_valid_reg      <= 1'b0;
            d_pend_upper_reg <= 1'b0;
            d_pend_self_reg  <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg      <= pop;
            c_valid_reg      <= b_valid_reg;
            p_valid_reg      <= c_valid_reg;
            d_valid_reg      <= p_valid_reg &&
                                (p_item_reg.emit_upper || p_item_reg.emit_self);
            d_pend_upper_reg <= p_item_reg.emit_upper;
            d_pend_self_reg  <= p_item_reg.emit_self;
        end
        else if (results.ready)
        begin
            // first of two results taken
            d_pend_upper_reg <= 1'b0;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_item_reg   <= q_head;
            c_item_reg   <= b_item_reg;
            c_center_reg <= center_q;
            c_lap_reg    <= lap_next;
            p_item_reg   <= c_item_reg;
            p_center_reg <= c_center_reg;
            p_prod_reg   <= prod_next;
            d_upper_reg  <= upper_next;
            d_self_reg   <= p_item_reg.cell_temperature;
            d_row_reg    <= p_item_reg.row;
            d_col_reg    <= p_item_reg.col;
            d_last_reg   <= p_item_reg.last;
            if (b_valid_reg)
            begin
                // row above, left of the next column
                west_reg <= center_q;
            end
        end
    end

    // Drive the result word: cell of the row above first
    assign results.valid           = d_valid_reg;
    assign results.new_temperature = d_pend_upper_reg ? d_upper_reg : d_self_reg;
    assign results.out_row         = d_pend_upper_reg ? d_row_reg - 1'b1 : d_row_reg;
    assign results.out_column      = d_col_reg;
    assign results.last_of_grid    = !d_pend_upper_reg && d_last_reg;

    a_valid_pending: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid_reg |-> (d_pend_upper_reg || d_pend_self_reg))
        else $error("output word valid with nothing pending");

    a_upper_row: assert property (@(posedge clk) disable iff (!rst_n)
        (d_valid_reg && d_pend_upper_reg) |-> (d_row_reg != '0))
        else $error("row above emitted for the first row");

    a_last_self: assert property (@(posedge clk) disable iff (!rst_n)
        (d_valid_reg && d_last_reg) |-> d_pend_self_reg)
        else $error("grid end flagged off the last row");

endmodule

### hdl/heat_stencil_five_point_step.sv
// Five-point heat stencil step: queue, then read, Laplacian, product, output registers.
// Throughput: one cell per cycle unless output stalls; a last-row cell gives two results
// from the single output register. Results for row r-1 leave as row r streams in.
// Reset: k = 66, 200 columns, 200 rows, position at row 0 column 0; the line
// stores are not cleared and need one full row before their data is used.
module heat_stencil_five_point_step (
    input  logic          clk,
    input  logic          rst_n,
    hsfp_cell_if.sink     cells,
    hsfp_result_if.source results,
    hsfp_cfg_if.sink      cfg
);
    import hsfp_pkg::*;

    logic               push;
    hsfp_item_t         push_item;
    logic               q_full;
    logic               q_empty;
    logic               pop;
    hsfp_item_t         q_head;
    logic [COEFF_W-1:0] coeff;

    // Accept and classify cells
    hsfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cells     (cells),
        .cfg       (cfg),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item),
        .coeff     (coeff)
    );

    // Decouple front from back
    hsfp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .head_item (q_head),
        .empty     (q_empty)
    );

    // Compute and emit
    hsfp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .coeff   (coeff),
        .q_empty (q_empty),
        .q_head  (q_head),
        .pop     (pop),
        .results (results)
    );

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for heat_stencil_five_point_step: streams Q16.16 grids and compares
// every updated cell with an in-bench predictor of the five-point diffusion step.
// Depends on hsfp_pkg, the three hsfp channel interfaces and the step module.
module tb_top;
    import hsfp_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 12;
    localparam int QUIET_LIMIT   = 3000;
    localparam int PRINT_LIMIT   = 50;
    localparam int NUM_VECTORS   = 20;

    // Index with no register behind it
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    localparam temp_t T_MAX   = 32'sh7FFF_FFFF;
    localparam temp_t T_MIN   = 32'sh8000_0000;
    localparam temp_t ONE     = 32'sh0001_0000;
    localparam temp_t NEG_ONE = 32'shFFFF_0000;
    localparam temp_t HUNDRED = 32'sh0064_0000;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct {
        temp_t            temperature;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic             last;
    } grid_result_t;

    // One directed word; upper_value and own_value are used only when typed is set
    typedef struct packed {
        temp_t temperature;
        logic  start;
        logic  typed;
        temp_t upper_value;
        temp_t own_value;
    } stencil_vector_t;

    // Two 3x3 grids at k near 0.5 (second one wraps without a start flag), then a restart
    // on the first cell of a third grid. Border cells pass through; the centre saturates.
    localparam stencil_vector_t DIRECTED_VECTORS [NUM_VECTORS] = '{
        '{ONE,     1'b1, 1'b1, 32'sd0, 32'sd0},
        '{T_MAX,   1'b0, 1'b1, 32'sd0, 32'sd0},
        '{T_MIN,   1'b0, 1'b1, 32'sd0, 32'sd0},
        '{T_MAX,   1'b0, 1'b1, ONE,    32'sd0},
        '{T_MIN,   1'b0, 1'b1, T_MAX,  32'sd0},
        '{T_MAX,   1'b0, 1'b1, T_MIN,  32'sd0},
        '{32'sd0,  1'b0, 1'b1, T_MAX,  32'sd0},
        '{T_MAX,   1'b0, 1'b1, T_MAX,  T_MAX},
        '{NEG_ONE, 1'b0, 1'b1, T_MAX,  NEG_ONE},
        '{32'sd0,  1'b0, 1'b1, 32'sd0, 32'sd0},
        '{T_MIN,   1'b0, 1'b1, 32'sd0, 32'sd0},
        '{32'sd0,  1'b0, 1'b1, 32'sd0, 32'sd0},
        '{T_MIN,   1'b0, 1'b1, 32'sd0, 32'sd0},
        '{T_MAX,   1'b0, 1'b1, T_MIN,  32'sd0},
        '{T_MIN,   1'b0, 1'b1, 32'sd0, 32'sd0},
        '{32'sd5,  1'b0, 1'b1, T_MIN,  32'sd5},
        '{T_MIN,   1'b0, 1'b1, T_MIN,  T_MIN},
        '{32'sd7,  1'b0, 1'b1, T_MIN,  32'sd7},
        '{32'sh0000_1234, 1'b1, 1'b0, 32'sd0, 32'sd0},
        '{32'shFFFF_ABCD, 1'b0, 1'b0, 32'sd0, 32'sd0}
    };

    logic clk;
    logic rst_n;

    hsfp_cell_if   cells_ch ();
    hsfp_result_if results_ch ();
    hsfp_cfg_if    cfg_ch ();

    heat_stencil_five_point_step dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cells   (cells_ch),
        .results (results_ch),
        .cfg     (cfg_ch)
    );

    // Predictor state: registers, line stores and raster position
    logic [COEFF_W-1:0] coeff_reg = COEFF_RESET;
    logic [COLS_W-1:0]  cols_reg  = COLUMNS_RESET;
    logic [ROWS_W-1:0]  rows_reg  = ROWS_RESET;
    temp_t recent_line [MAX_COLUMNS] = '{default: '0};
    temp_t older_line  [MAX_COLUMNS] = '{default: '0};
    int row_pos = 0;
    int col_pos = 0;

    grid_result_t awaited_cells [$];
    grid_result_t checked_cell;
    int mismatch_count = 0;
    int quiet_cycles   = 0;

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int hold_len      = 300;
    int hold_seq      = 0;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Work out the updated cells caused by one accepted word and queue them
    function automatic void advance_grid(temp_t value_in, logic start, logic typed,
                                         temp_t upper_value, temp_t own_value);
        int ncols;
        int nrows;
        longint lap;
        longint sum;
        grid_result_t res;
        ncols = int'(cols_reg);
        if (ncols < MIN_DIM) ncols = MIN_DIM;
        if (ncols > MAX_COLUMNS) ncols = MAX_COLUMNS;
        nrows = int'(rows_reg);
        if (nrows < MIN_DIM) nrows = MIN_DIM;
        if (nrows > MAX_ROWS) nrows = MAX_ROWS;

        if (start)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        // wrap a position left outside the grid by a smaller configuration
        if (col_pos >= ncols)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= nrows) row_pos = 0;

        // emit the cell of the row above
        if (row_pos >= 1)
        begin
            res.row    = ROW_W'(row_pos - 1);
            res.column = COL_W'(col_pos);
            res.last   = 1'b0;
            if (row_pos == 1 || col_pos == 0 || col_pos == ncols - 1)
                res.temperature = recent_line[col_pos];
            else
            begin
                lap = longint'(older_line[col_pos]) + longint'(value_in)
                    + longint'(older_line[col_pos-1]) + longint'(recent_line[col_pos+1])
                    - 4 * longint'(recent_line[col_pos]);
                sum = longint'(recent_line[col_pos])
                    + ((lap * longint'(coeff_reg)) >>> FRAC_W);
                if (sum > longint'(T_MAX))
                    res.temperature = T_MAX;
                else if (sum < longint'(T_MIN))
                    res.temperature = T_MIN;
                else
                    res.temperature = temp_t'(sum);
            end
            if (typed) res.temperature = upper_value;
            awaited_cells.push_back(res);
        end

        // last row: pass the arriving cell straight out as well
        if (row_pos == nrows - 1)
        begin
            res.temperature = typed ? own_value : value_in;
            res.row         = ROW_W'(row_pos);
            res.column      = COL_W'(col_pos);
            res.last        = (col_pos == ncols - 1);
            awaited_cells.push_back(res);
        end

        older_line[col_pos]  = recent_line[col_pos];
        recent_line[col_pos] = value_in;

        // advance the raster position
        col_pos++;
        if (col_pos >= ncols)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= nrows) row_pos = 0;
        end
    endfunction

    task automatic report_mismatch(string what, logic [TEMP_W-1:0] got,
                                   logic [TEMP_W-1:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic set_idling(idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            IDLE_SENDER:   begin src_idle_pct = 46; snk_stall_pct = 0;  end
            IDLE_RECEIVER: begin src_idle_pct = 0;  snk_stall_pct = 46; end
            default:       begin src_idle_pct = 7;  snk_stall_pct = 7;  end
        endcase
    endtask

    // Offer one word, idling first at random, and predict once it is taken
    task automatic send_cell(temp_t value_in, logic start, logic typed,
                             temp_t upper_value, temp_t own_value);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            cells_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cells_ch.valid            <= 1'b1;
        cells_ch.cell_temperature <= value_in;
        cells_ch.grid_start       <= start;
        do @(posedge clk); while (!cells_ch.ready);
        advance_grid(value_in, start, typed, upper_value, own_value);
    endtask

    // Drop valid and wait for every awaited cell, then let the pipeline settle
    task automatic drain_results();
        @(negedge clk);
        cells_ch.valid <= 1'b0;
        while (awaited_cells.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            CFG_COEFF:   coeff_reg = value[COEFF_W-1:0];
            CFG_COLUMNS: cols_reg  = value[COLS_W-1:0];
            CFG_ROWS:    rows_reg  = value[ROWS_W-1:0];
            default:     ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic configure(int coeff, int columns, int rows);
        write_reg(CFG_COEFF, CFG_DATA_W'(coeff));
        write_reg(CFG_COLUMNS, CFG_DATA_W'(columns));
        write_reg(CFG_ROWS, CFG_DATA_W'(rows));
    endtask

    // Stream random grids: mostly moderate temperatures, some full-range words,
    // and an occasional stray start flag that restarts the grid
    task automatic stream_cells(int count, int noise_pct, int wide_pct, int hold_at,
                                int pause_at, bit opens_grid);
        int pick;
        logic start;
        temp_t value_in;
        for (int i = 0; i < count; i++)
        begin
            pick = int'($urandom_range(99));
            if (pick < wide_pct)
                value_in = temp_t'($urandom);
            else if (pick < wide_pct + 3)
                value_in = ($urandom_range(1) != 0) ? T_MAX : T_MIN;
            else
                value_in = temp_t'($urandom_range(32'd13107200)) - HUNDRED;
            start = (i == 0 && opens_grid) || ($urandom_range(99) < noise_pct);
            if (i == pause_at) drain_results();
            send_cell(value_in, start, 1'b0, '0, '0);
            if (i == hold_at) hold_seq++;
        end
        drain_results();
    endtask

    // Result sink: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        results_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                hold_left = hold_len;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                results_ch.ready <= 1'b0;
            end
            else
                results_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Compare each accepted result with the oldest awaited cell
    always @(posedge clk)
    begin
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            if (awaited_cells.size() == 0)
                report_mismatch("result with none awaited", results_ch.new_temperature, '0);
            else
            begin
                checked_cell = awaited_cells.pop_front();
                if (results_ch.new_temperature !== checked_cell.temperature)
                    report_mismatch("new_temperature", results_ch.new_temperature,
                                    checked_cell.temperature);
                if (results_ch.out_row !== checked_cell.row)
                    report_mismatch("out_row", TEMP_W'(results_ch.out_row),
                                    TEMP_W'(checked_cell.row));
                if (results_ch.out_column !== checked_cell.column)
                    report_mismatch("out_column", TEMP_W'(results_ch.out_column),
                                    TEMP_W'(checked_cell.column));
                if (results_ch.last_of_grid !== checked_cell.last)
                    report_mismatch("last_of_grid", TEMP_W'(results_ch.last_of_grid),
                                    TEMP_W'(checked_cell.last));
            end
        end
    end

    // Watchdog: end the run after too long with no word moving on any channel
    always @(posedge clk)
    begin
        if ((cells_ch.valid && cells_ch.ready) || (results_ch.valid && results_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n                     = 1'b0;
        cells_ch.valid            = 1'b0;
        cells_ch.cell_temperature = '0;
        cells_ch.grid_start       = 1'b0;
        cfg_ch.valid              = 1'b0;
        cfg_ch.index              = CFG_COEFF;
        cfg_ch.data               = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: k above the stable range, both dimensions clamped up to 3
        set_idling(IDLE_NONE);
        configure(32767, 0, 1);
        for (int i = 0; i < NUM_VECTORS; i++)
            send_cell(DIRECTED_VECTORS[i].temperature, DIRECTED_VECTORS[i].start,
                      DIRECTED_VECTORS[i].typed, DIRECTED_VECTORS[i].upper_value,
                      DIRECTED_VECTORS[i].own_value);
        drain_results();

        // Small grids at the stability limit, no idling
        configure(16384, 5, 4);
        stream_cells(80, 2, 10, -1, -1, 1'b1);

        // Shrink columns, then rows, in the middle of a grid
        set_idling(IDLE_SENDER);
        configure(66, 8, 6);
        stream_cells(20, 0, 10, -1, -1, 1'b1);
        write_reg(CFG_COLUMNS, CFG_DATA_W'(4));
        stream_cells(10, 0, 10, -1, -1, 1'b0);
        write_reg(CFG_ROWS, CFG_DATA_W'(3));
        stream_cells(20, 0, 10, -1, -1, 1'b0);

        // Random shape, receiver stalls, one long hold-off
        set_idling(IDLE_RECEIVER);
        configure(int'($urandom_range(16384)), int'($urandom_range(3, 20)),
                  int'($urandom_range(3, 12)));
        stream_cells(100, 3, 10, 50, -1, 1'b1);

        // k of zero; upper data bits set and masked off; pause until drained
        set_idling(IDLE_BOTH);
        configure(0, 16'hFE05, 16'hE007);
        stream_cells(60, 2, 10, -1, 30, 1'b1);

        // Smallest grid with many full-range words to force saturation
        set_idling(IDLE_SENDER);
        configure(32767, 3, 3);
        stream_cells(40, 0, 40, -1, -1, 1'b1);

        // Widest grid, column count clamped down, hold-off with a busy sender
        set_idling(IDLE_NONE);
        configure(16384, 511, 3);
        stream_cells(2 * MAX_COLUMNS + 16, 0, 10, 300, -1, 1'b1);

        // Row count clamped down, columns clamped up; the grid stays open
        set_idling(IDLE_RECEIVER);
        configure(int'($urandom_range(16384)), 2, 8191);
        stream_cells(30, 0, 10, -1, -1, 1'b1);

        // Write to the unused index, then a last random shape
        set_idling(IDLE_BOTH);
        write_reg(CFG_UNUSED, 16'hFFFF);
        configure(int'($urandom_range(32767)), int'($urandom_range(3, 40)),
                  int'($urandom_range(3, 10)));
        stream_cells(60, 3, 10, -1, 30, 1'b1);

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
hdl/hsfp_pkg.sv
hdl/hsfp_cell_if.sv
hdl/hsfp_result_if.sv
hdl/hsfp_cfg_if.sv
hdl/hsfp_ram.sv
hdl/hsfp_queue.sv
hdl/hsfp_front.sv
hdl/hsfp_back.sv
hdl/heat_stencil_five_point_step.sv
bench/tb_top.sv
